@@ hdl/pal_pkg.sv @@
// ----------------------------------------------------------------------------
// pal_pkg
// Shared types and constants for the positional array list: opcodes, the
// per-cell command broadcast along the chain, and list sizing.
// ----------------------------------------------------------------------------
package pal_pkg;

    // list sizing (fixed by the 7-bit position and count fields)
    localparam int DEPTH     = 64;
    localparam int CNT_W     = 7;
    localparam int DATA_W    = 32;
    localparam int CAP_RESET = 64;

    // operation codes on the input channel
    typedef enum logic [1:0] {
        OP_READ   = 2'd0,
        OP_WRITE  = 2'd1,
        OP_INSERT = 2'd2,
        OP_REMOVE = 2'd3
    } op_t;

    // action every cell takes on each cycle
    typedef enum logic [1:0] {
        CELL_HOLD   = 2'd0,
        CELL_WRITE  = 2'd1,
        CELL_INSERT = 2'd2,
        CELL_REMOVE = 2'd3
    } cell_op_t;

    // command broadcast to the whole chain
    typedef struct packed {
        cell_op_t            op;
        logic [CNT_W-1:0]    slot;   // 0-based target position
        logic [DATA_W-1:0]   value;
    } cell_cmd_t;

endpackage

@@ hdl/positional_array_list.sv @@
// Result: a transaction accepted at one clock edge has its result in the
//   output register after that edge.
// Throughput: one transaction per cycle unless out_ready stalls; all cells
//   shift in the same cycle, so inserts and removes cost no more than reads.
// Reset: clears the entry count and output valid and sets capacity to 64;
//   entry words are not cleared and need no clearing pass.
// ----------------------------------------------------------------------------
// positional_array_list
// Ordered list of signed words addressed by 1-based position, built as a
// chain of cells. Supports read, overwrite, insert and remove per position.
// ----------------------------------------------------------------------------
module positional_array_list (
    input  logic                              clk,
    input  logic                              rst_n,
    // input channel
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [1:0]                        op,
    input  logic [pal_pkg::CNT_W-1:0]         pos,
    input  logic signed [pal_pkg::DATA_W-1:0] value,
    // result channel
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic                              ok,
    output logic signed [pal_pkg::DATA_W-1:0] read_data,
    output logic [pal_pkg::CNT_W-1:0]         count,
    output logic                              empty_res,
    output logic                              full_res,
    // configuration
    input  logic                              cfg_we,
    input  logic [pal_pkg::CNT_W-1:0]         cfg_data
);
    import pal_pkg::*;

    logic [CNT_W-1:0]  capacity_reg;
    logic [CNT_W-1:0]  count_reg;
    logic [CNT_W-1:0]  count_next;
    logic              out_valid_reg;
    logic              ok_reg;
    logic [DATA_W-1:0] read_data_reg;
    logic [CNT_W-1:0]  count_out_reg;
    logic              empty_reg;
    logic              full_reg;

    logic [CNT_W-1:0]  cap_eff;
    logic [CNT_W-1:0]  slot;
    logic              in_span;
    logic              ins_ok;
    logic              accept;
    logic              op_ok;
    logic [DATA_W-1:0] rd_word;
    logic [DATA_W-1:0] tap_or;
    cell_op_t          cell_op;
    cell_cmd_t         cmd;

    logic [DATA_W-1:0] cell_data  [DEPTH];
    logic [DATA_W-1:0] cell_tap   [DEPTH];
    logic [DATA_W-1:0] left_arr   [DEPTH];
    logic [DATA_W-1:0] right_arr  [DEPTH];

    // effective capacity, saturated into 1..DEPTH
    always_comb
    begin
        if (capacity_reg == '0)
            cap_eff = CNT_W'(1);
        else if (capacity_reg > CNT_W'(DEPTH))
            cap_eff = CNT_W'(DEPTH);
        else
            cap_eff = capacity_reg;
    end

    assign in_ready = !out_valid_reg || out_ready;
    assign accept   = in_valid && in_ready;

    // position checks
    assign slot    = pos - CNT_W'(1);
    assign in_span = (pos != '0) && (pos <= count_reg);
    assign ins_ok  = (count_reg < cap_eff) && (count_reg < CNT_W'(DEPTH)) &&
                     (pos != '0) && (pos <= count_reg + CNT_W'(1));

    // read tap reduction across the chain
    always_comb
    begin
        tap_or = '0;
        for (int i = 0; i < DEPTH; i++)
            tap_or = tap_or | cell_tap[i];
    end

    // decode the operation
    always_comb
    begin
        op_ok      = 1'b0;
        cell_op    = CELL_HOLD;
        count_next = count_reg;
        rd_word    = '0;
        case (op_t'(op))
            OP_READ:
            begin
                op_ok   = in_span;
                rd_word = in_span ? tap_or : '1;
            end
            OP_WRITE:
            begin
                op_ok   = in_span;
                cell_op = CELL_WRITE;
            end
            OP_INSERT:
            begin
                op_ok   = ins_ok;
                cell_op = CELL_INSERT;
                if (ins_ok)
                    count_next = count_reg + CNT_W'(1);
            end
            OP_REMOVE:
            begin
                op_ok   = in_span;
                cell_op = CELL_REMOVE;
                if (in_span)
                    count_next = count_reg - CNT_W'(1);
            end
            default:
            begin
                op_ok = 1'b0;
            end
        endcase
    end

    // broadcast command, only for a successful accepted transaction
    always_comb
    begin
        cmd.op    = (accept && op_ok) ? cell_op : CELL_HOLD;
        cmd.slot  = slot;
        cmd.value = value;
    end

    // chain of cells, each wired to its neighbors
    for (genvar g = 0; g < DEPTH; g++)
    begin : g_cell
        if (g == 0)
        begin : g_first
            assign left_arr[g] = cell_data[g];
        end
        else
        begin : g_left
            assign left_arr[g] = cell_data[g-1];
        end
        if (g == DEPTH - 1)
        begin : g_last
            assign right_arr[g] = cell_data[g];
        end
        else
        begin : g_right
            assign right_arr[g] = cell_data[g+1];
        end

        pal_cell #(
            .INDEX (g)
        ) u_cell (
            .clk        (clk),
            .cmd        (cmd),
            .left_data  (left_arr[g]),
            .right_data (right_arr[g]),
            .data       (cell_data[g]),
            .tap_data   (cell_tap[g])
        );
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg  <= CNT_W'(CAP_RESET);
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
                capacity_reg <= cfg_data;
            if (accept)
                count_reg <= count_next;
            if (accept)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    // result register
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            ok_reg        <= op_ok;
            read_data_reg <= rd_word;
            count_out_reg <= count_next;
            empty_reg     <= (count_next == '0);
            full_reg      <= (count_next >= cap_eff);
        end
    end

    assign out_valid = out_valid_reg;
    assign ok        = ok_reg;
    assign read_data = read_data_reg;
    assign count     = count_out_reg;
    assign empty_res = empty_reg;
    assign full_res  = full_reg;

endmodule

@@ hdl/pal_cell.sv @@
// ----------------------------------------------------------------------------
// pal_cell
// One list entry. Holds a word and, on each cycle, keeps it, takes the
// broadcast value, or takes the word of its left or right neighbor.
// ----------------------------------------------------------------------------
module pal_cell #(
    parameter int INDEX = 0
) (
    input  logic                        clk,
    input  pal_pkg::cell_cmd_t          cmd,
    input  logic [pal_pkg::DATA_W-1:0]  left_data,
    input  logic [pal_pkg::DATA_W-1:0]  right_data,
    output logic [pal_pkg::DATA_W-1:0]  data,
    output logic [pal_pkg::DATA_W-1:0]  tap_data
);
    import pal_pkg::*;

    logic [CNT_W-1:0]  my_idx;
    logic [DATA_W-1:0] data_reg;
    logic [DATA_W-1:0] data_next;

    assign my_idx = CNT_W'(INDEX);

    // next word for this cell
    always_comb
    begin
        data_next = data_reg;
        case (cmd.op)
            CELL_WRITE:
            begin
                if (my_idx == cmd.slot)
                    data_next = cmd.value;
            end
            CELL_INSERT:
            begin
                if (my_idx > cmd.slot)
                    data_next = left_data;
                else if (my_idx == cmd.slot)
                    data_next = cmd.value;
            end
            CELL_REMOVE:
            begin
                if (my_idx >= cmd.slot)
                    data_next = right_data;
            end
            default:
            begin
                data_next = data_reg;
            end
        endcase
    end

    // entry storage, undefined until written
    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data     = data_reg;
    // read tap: only the addressed cell drives a nonzero word
    assign tap_data = (my_idx == cmd.slot) ? data_reg : '0;

endmodule

@@ hdl/pal_checker.sv @@
// ----------------------------------------------------------------------------
// pal_checker
// Port-level checks for the positional array list, bound to the top level.
// ----------------------------------------------------------------------------
module pal_checker (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_ready,
    input  logic                              out_valid,
    input  logic                              out_ready,
    input  logic                              ok,
    input  logic signed [pal_pkg::DATA_W-1:0] read_data,
    input  logic [pal_pkg::CNT_W-1:0]         count,
    input  logic                              empty_res,
    input  logic                              full_res
);
    import pal_pkg::*;

    // a stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(read_data) && $stable(count))
        else $error("result changed while stalled");

    // empty flag agrees with the count
    a_empty: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (empty_res == (count == '0)))
        else $error("empty flag disagrees with count");

    // count never exceeds the list depth, and a full list is never empty
    a_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (count <= CNT_W'(DEPTH)) && !(full_res && empty_res))
        else $error("count out of range");

    // a failed transaction returns zero or the all-ones read word
    a_fail: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !ok |-> (read_data == '0) || (read_data == '1))
        else $error("bad read word on failure");

    // input is taken whenever the result side is free
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled with empty result register");

endmodule

bind positional_array_list pal_checker u_pal_checker (.*);

@@ tb/testbench.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for positional_array_list. A directed table covers an
// empty list, position zero and out-of-span positions, and word extremes.
// Random phases then run under several capacity settings, predicted by a
// behavioral list model, with random stalls on both channels.
// ----------------------------------------------------------------------------
module testbench;
    import pal_pkg::*;

    // one result transaction
    typedef struct packed {
        logic                     ok;
        logic signed [DATA_W-1:0] read_data;
        logic [CNT_W-1:0]         count;
        logic                     empty_res;
        logic                     full_res;
    } list_result_t;

    // one directed row; typed rows carry their own expected result
    typedef struct packed {
        op_t                      op;
        logic [CNT_W-1:0]         pos;
        logic signed [DATA_W-1:0] value;
        bit                       typed;
        list_result_t             res;
    } stim_row_t;

    localparam list_result_t NO_RES = '0;

    logic                     clk = 1'b0;
    logic                     rst_n = 1'b0;
    logic                     in_valid = 1'b0;
    logic                     in_ready;
    logic [1:0]               op = OP_READ;
    logic [CNT_W-1:0]         pos = '0;
    logic signed [DATA_W-1:0] value = '0;
    logic                     out_valid;
    logic                     out_ready = 1'b0;
    logic                     ok;
    logic signed [DATA_W-1:0] read_data;
    logic [CNT_W-1:0]         count;
    logic                     empty_res;
    logic                     full_res;
    logic                     cfg_we = 1'b0;
    logic [CNT_W-1:0]         cfg_data = '0;

    // typed expectation travels with the payload of a directed row
    bit                       row_typed = 1'b0;
    list_result_t             row_expect = '0;

    // list model state
    logic signed [DATA_W-1:0] list_words [DEPTH];
    int unsigned              list_count = 0;
    logic [CNT_W-1:0]         list_capacity = CNT_W'(CAP_RESET);

    list_result_t             expected_results [$];
    int                       mismatches = 0;
    bit                       steady = 1'b0;

    stim_row_t directed_rows [0:23] = '{
        '{OP_READ,   7'd1,   32'sd0,          1'b1, '{1'b0, -32'sd1, 7'd0, 1'b1, 1'b0}},
        '{OP_REMOVE, 7'd1,   32'sd0,          1'b1, '{1'b0, 32'sd0,  7'd0, 1'b1, 1'b0}},
        '{OP_WRITE,  7'd0,   32'sd5,          1'b1, '{1'b0, 32'sd0,  7'd0, 1'b1, 1'b0}},
        '{OP_INSERT, 7'd0,   32'sd5,          1'b1, '{1'b0, 32'sd0,  7'd0, 1'b1, 1'b0}},
        '{OP_INSERT, 7'd2,   32'sd5,          1'b1, '{1'b0, 32'sd0,  7'd0, 1'b1, 1'b0}},
        '{OP_INSERT, 7'd1,   32'sh7fffffff,   1'b1, '{1'b1, 32'sd0,  7'd1, 1'b0, 1'b0}},
        '{OP_INSERT, 7'd2,   32'sh80000000,   1'b1, '{1'b1, 32'sd0,  7'd2, 1'b0, 1'b0}},
        '{OP_INSERT, 7'd1,   -32'sd1,         1'b1, '{1'b1, 32'sd0,  7'd3, 1'b0, 1'b0}},
        '{OP_READ,   7'd1,   32'sd0,          1'b1, '{1'b1, -32'sd1, 7'd3, 1'b0, 1'b0}},
        '{OP_READ,   7'd3,   32'sd0,          1'b1,
          '{1'b1, 32'sh80000000, 7'd3, 1'b0, 1'b0}},
        '{OP_READ,   7'd2,   32'sd0,          1'b1,
          '{1'b1, 32'sh7fffffff, 7'd3, 1'b0, 1'b0}},
        '{OP_READ,   7'd4,   32'sd0,          1'b1, '{1'b0, -32'sd1, 7'd3, 1'b0, 1'b0}},
        '{OP_READ,   7'd127, 32'sd0,          1'b1, '{1'b0, -32'sd1, 7'd3, 1'b0, 1'b0}},
        '{OP_WRITE,  7'd2,   32'sd0,          1'b1, '{1'b1, 32'sd0,  7'd3, 1'b0, 1'b0}},
        '{OP_WRITE,  7'd127, 32'sd1,          1'b1, '{1'b0, 32'sd0,  7'd3, 1'b0, 1'b0}},
        '{OP_INSERT, 7'd127, 32'sd1,          1'b1, '{1'b0, 32'sd0,  7'd3, 1'b0, 1'b0}},
        '{OP_REMOVE, 7'd127, 32'sd0,          1'b1, '{1'b0, 32'sd0,  7'd3, 1'b0, 1'b0}},
        '{OP_REMOVE, 7'd2,   32'sd0,          1'b1, '{1'b1, 32'sd0,  7'd2, 1'b0, 1'b0}},
        '{OP_READ,   7'd2,   32'sd0,          1'b0, NO_RES},
        '{OP_INSERT, 7'd2,   32'sh55555555,   1'b0, NO_RES},
        '{OP_REMOVE, 7'd1,   32'sd0,          1'b0, NO_RES},
        '{OP_READ,   7'd1,   32'sd0,          1'b0, NO_RES},
        '{OP_WRITE,  7'd2,   32'sh2aaaaaaa,   1'b0, NO_RES},
        '{OP_REMOVE, 7'd2,   32'sd0,          1'b0, NO_RES}
    };

    positional_array_list dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .op        (op),
        .pos       (pos),
        .value     (value),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .ok        (ok),
        .read_data (read_data),
        .count     (count),
        .empty_res (empty_res),
        .full_res  (full_res),
        .cfg_we    (cfg_we),
        .cfg_data  (cfg_data)
    );

    // clock
    initial
    begin
        forever #5 clk = ~clk;
    end

    // capacity as the list applies it: saturated into 1..DEPTH
    function automatic int unsigned capacity_limit();
        if (list_capacity == 0)
            return 1;
        if (list_capacity > DEPTH)
            return DEPTH;
        return list_capacity;
    endfunction

    // apply one operation to the list model and return its result
    function automatic list_result_t apply_list_op(op_t o, logic [CNT_W-1:0] p,
                                                   logic signed [DATA_W-1:0] v);
        list_result_t r;
        int unsigned  limit;
        int           idx;
        bit           in_span;
        limit   = capacity_limit();
        r       = '0;
        in_span = (p >= 1) && (int'(p) <= list_count);
        case (o)
            OP_READ:
            begin
                if (in_span)
                begin
                    r.read_data = list_words[p - 1];
                    r.ok        = 1'b1;
                end
                else
                    r.read_data = '1;
            end
            OP_WRITE:
            begin
                if (in_span)
                begin
                    list_words[p - 1] = v;
                    r.ok              = 1'b1;
                end
            end
            OP_INSERT:
            begin
                if (list_count < limit && p >= 1 && int'(p) <= list_count + 1)
                begin
                    for (idx = list_count; idx > int'(p) - 1; idx--)
                        list_words[idx] = list_words[idx - 1];
                    list_words[p - 1] = v;
                    list_count++;
                    r.ok = 1'b1;
                end
            end
            default:
            begin
                if (in_span)
                begin
                    for (idx = int'(p) - 1; idx + 1 < list_count; idx++)
                        list_words[idx] = list_words[idx + 1];
                    list_count--;
                    r.ok = 1'b1;
                end
            end
        endcase
        r.count     = CNT_W'(list_count);
        r.empty_res = (list_count == 0);
        r.full_res  = (list_count >= limit);
        return r;
    endfunction

    task automatic flag_mismatch(input string what, input logic [DATA_W-1:0] got,
                                 input logic [DATA_W-1:0] want);
        if (mismatches < 100)
            $display("MISMATCH at %0t: %s got %0h expected %0h", $time, what, got, want);
        mismatches++;
    endtask

    // result checking and prediction of accepted transactions
    always @(posedge clk)
    begin
        list_result_t got;
        list_result_t want;
        if (rst_n)
        begin
            if (out_valid && out_ready)
            begin
                got = '{ok, read_data, count, empty_res, full_res};
                if (expected_results.size() == 0)
                    flag_mismatch("result with none pending", got.read_data, '0);
                else
                begin
                    want = expected_results.pop_front();
                    if (got.ok !== want.ok)
                        flag_mismatch("ok", DATA_W'(got.ok), DATA_W'(want.ok));
                    if (got.read_data !== want.read_data)
                        flag_mismatch("read_data", got.read_data, want.read_data);
                    if (got.count !== want.count)
                        flag_mismatch("count", DATA_W'(got.count), DATA_W'(want.count));
                    if (got.empty_res !== want.empty_res)
                        flag_mismatch("empty_res", DATA_W'(got.empty_res),
                                      DATA_W'(want.empty_res));
                    if (got.full_res !== want.full_res)
                        flag_mismatch("full_res", DATA_W'(got.full_res),
                                      DATA_W'(want.full_res));
                end
            end
            if (in_valid && in_ready)
            begin
                want = apply_list_op(op_t'(op), pos, value);
                if (row_typed)
                    want = row_expect;
                expected_results.push_back(want);
            end
        end
    end

    // result side backpressure
    always @(negedge clk)
        out_ready <= steady || ($urandom_range(99) >= 26);

    // present one transaction and hold it until accepted
    task automatic send_item(input op_t o, input logic [CNT_W-1:0] p,
                             input logic signed [DATA_W-1:0] v,
                             input bit typed, input list_result_t res);
        while (!steady && $urandom_range(99) < 26)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid   <= 1'b1;
        op         <= o;
        pos        <= p;
        value      <= v;
        row_typed  <= typed;
        row_expect <= res;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        @(negedge clk);
    endtask

    // mostly in-span positions, some anywhere in the 7-bit range
    task automatic send_random(input int ins_pct, input int rem_pct);
        op_t                      o;
        logic [CNT_W-1:0]         p;
        logic signed [DATA_W-1:0] v;
        int unsigned              roll;
        int unsigned              span;
        roll = $urandom_range(99);
        if (roll < ins_pct)
            o = OP_INSERT;
        else if (roll < ins_pct + rem_pct)
            o = OP_REMOVE;
        else if ($urandom_range(1) == 1)
            o = OP_READ;
        else
            o = OP_WRITE;
        span = (o == OP_INSERT) ? list_count + 1 : list_count;
        if (span == 0 || $urandom_range(99) < 12)
            p = CNT_W'($urandom_range(127));
        else
            p = CNT_W'($urandom_range(span, 1));
        case ($urandom_range(7))
            0: v = 32'sh80000000;
            1: v = 32'sh7fffffff;
            2: v = -32'sd1;
            3: v = 32'sd0;
            default: v = $urandom;
        endcase
        send_item(o, p, v, 1'b0, NO_RES);
    endtask

    // drop valid and let every pending result drain
    task automatic settle();
        in_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(negedge clk);
        repeat (2) @(negedge clk);
    endtask

    // write capacity while idle, then run random transactions
    task automatic run_phase(input logic [CNT_W-1:0] cap, input int items,
                             input int ins_pct, input int rem_pct);
        settle();
        cfg_we   <= 1'b1;
        cfg_data <= cap;
        @(negedge clk);
        cfg_we        <= 1'b0;
        list_capacity = cap;
        repeat (items) send_random(ins_pct, rem_pct);
    endtask

    // stimulus
    initial
    begin
        repeat (9) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        foreach (directed_rows[i])
            send_item(directed_rows[i].op, directed_rows[i].pos, directed_rows[i].value,
                      directed_rows[i].typed, directed_rows[i].res);
        // zero capacity acts as one and sits at the current count
        run_phase(7'd0, 50, 30, 20);
        run_phase(7'd1, 40, 40, 30);
        // above DEPTH saturates; insert-heavy to fill the whole list
        run_phase(7'd127, 160, 65, 10);
        // lowered well below count
        run_phase(7'd5, 70, 20, 50);
        steady = 1'b1;
        run_phase(7'd64, 100, 35, 35);
        steady = 1'b0;
        run_phase(CNT_W'($urandom_range(63, 2)), 120, 40, 40);
        run_phase(7'd2, 60, 45, 35);
        settle();
        repeat (5) @(negedge clk);
        if (mismatches == 0)
        begin
            $display("SUCCESS");
        end
        else
        begin
            $display("FAILURE");
        end
        $finish;
    end

    // watchdog
    initial
    begin
        #2000000;
        $display("FAILURE");
        $finish;
    end

endmodule

@@ positional_array_list.f @@
hdl/pal_pkg.sv
hdl/pal_cell.sv
hdl/positional_array_list.sv
hdl/pal_checker.sv
tb/testbench.sv
